FILE: sv/sha2_pkg.sv
// shared types, constants and round tables for the sha-256/224 hasher
`timescale 1ns / 1ps

package sha2_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned FillW  = 6;
  localparam int unsigned LenW   = 61;
  localparam int unsigned NumBuf = 16;
  localparam int unsigned NumHash = 8;

  localparam logic [FillW-1:0] FillLast = 6'h3f;
  localparam logic [FillW-1:0] FillLen  = 6'd56;
  localparam logic [7:0]       PadByte  = 8'h80;
  localparam logic [5:0]       LastRound = 6'd63;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DATA  = 8'b0000_0010,
    ST_PAD   = 8'b0000_0100,
    ST_ZERO  = 8'b0000_1000,
    ST_LEN   = 8'b0001_0000,
    ST_ROUND = 8'b0010_0000,
    ST_FIN   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  typedef enum logic [1:0] {
    BS_DATA = 2'd0,
    BS_PAD  = 2'd1,
    BS_ZERO = 2'd2,
    BS_LEN  = 2'd3
  } bsel_e;

  typedef struct packed {
    logic       load;
    logic       put;
    bsel_e      bsel;
    logic [1:0] bidx;
    logic       init_rnd;
    logic       rnd_step;
    logic [5:0] rnd_idx;
    logic       finish;
    logic       restart;
    logic [2:0] oidx;
  } cmd_t;

  typedef struct packed {
    logic [FillW-1:0] fill;
    logic [2:0]       cnt;
    logic             msg_end;
  } status_t;

  function automatic logic [31:0] iv_fn(input logic mode, input logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0: r = mode ? 32'hc1059ed8 : 32'h6a09e667;
      3'd1: r = mode ? 32'h367cd507 : 32'hbb67ae85;
      3'd2: r = mode ? 32'h3070dd17 : 32'h3c6ef372;
      3'd3: r = mode ? 32'hf70e5939 : 32'ha54ff53a;
      3'd4: r = mode ? 32'hffc00b31 : 32'h510e527f;
      3'd5: r = mode ? 32'h68581511 : 32'h9b05688c;
      3'd6: r = mode ? 32'h64f98fa7 : 32'h1f83d9ab;
      default: r = mode ? 32'hbefa4fa4 : 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] k_fn(input logic [5:0] i);
    logic [31:0] r;
    unique case (i)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;  6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5;  6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;  6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01;  6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/sha2_dp.sv
// datapath: block buffer, message schedule, round registers and hash state
`timescale 1ns / 1ps

module sha2_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mode_i,
  input  logic [31:0]      word_i,
  input  logic [2:0]       cnt_i,
  input  logic             end_i,
  input  sha2_pkg::cmd_t   cmd_i,
  output sha2_pkg::status_t sts_o,
  output logic [31:0]      digest_o
);

  logic [31:0] hash_q [sha2_pkg::NumHash];
  logic [31:0] hash_d [sha2_pkg::NumHash];
  logic [31:0] buf_q  [sha2_pkg::NumBuf];
  logic [31:0] buf_d  [sha2_pkg::NumBuf];
  logic [31:0] v_q    [8];
  logic [31:0] v_d    [8];
  logic [sha2_pkg::FillW-1:0] fill_q, fill_d;
  logic [sha2_pkg::LenW-1:0]  len_q, len_d;
  logic [31:0] word_q;
  logic [2:0]  cnt_q;
  logic        end_q;
  logic [2:0]  cnt_sat;
  logic [7:0]  byte_w;
  logic [31:0] wsh;
  logic [63:0] bits, bsh;
  logic [31:0] s0, s1, wnew, e1, ch, e0, mj, t1;

  assign cnt_sat = (cnt_i > 3'd4) ? 3'd4 : cnt_i;
  assign wsh  = word_q << {cmd_i.bidx, 3'b000};
  assign bits = {len_q, 3'b000};
  assign bsh  = bits << {fill_q[2:0], 3'b000};

  always_comb begin
    unique case (cmd_i.bsel)
      sha2_pkg::BS_DATA: byte_w = wsh[31:24];
      sha2_pkg::BS_PAD:  byte_w = sha2_pkg::PadByte;
      sha2_pkg::BS_ZERO: byte_w = 8'h00;
      default:           byte_w = bsh[63:56];
    endcase
  end

  assign s0 = {buf_q[1][6:0], buf_q[1][31:7]} ^ {buf_q[1][17:0], buf_q[1][31:18]}
            ^ (buf_q[1] >> 3);
  assign s1 = {buf_q[14][16:0], buf_q[14][31:17]} ^ {buf_q[14][18:0], buf_q[14][31:19]}
            ^ (buf_q[14] >> 10);
  assign wnew = s1 + buf_q[9] + s0 + buf_q[0];
  assign e1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
            ^ {v_q[4][24:0], v_q[4][31:25]};
  assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1 = v_q[7] + e1 + ch + sha2_pkg::k_fn(cmd_i.rnd_idx) + buf_q[0];
  assign e0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
            ^ {v_q[0][21:0], v_q[0][31:22]};
  assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);

  always_comb begin
    hash_d = hash_q;
    buf_d  = buf_q;
    v_d    = v_q;
    fill_d = fill_q;
    len_d  = len_q;
    if (cmd_i.load) begin
      len_d = len_q + sha2_pkg::LenW'(cnt_sat);
    end
    if (cmd_i.put) begin
      unique case (fill_q[1:0])
        2'd0: buf_d[fill_q[5:2]][31:24] = byte_w;
        2'd1: buf_d[fill_q[5:2]][23:16] = byte_w;
        2'd2: buf_d[fill_q[5:2]][15:8]  = byte_w;
        default: buf_d[fill_q[5:2]][7:0] = byte_w;
      endcase
      fill_d = fill_q + 6'd1;
    end
    if (cmd_i.init_rnd) begin
      v_d = hash_q;
    end
    if (cmd_i.rnd_step) begin
      for (int j = 0; j < 15; j++) buf_d[j] = buf_q[j+1];
      buf_d[15] = wnew;
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + e0 + mj;
    end
    if (cmd_i.finish) begin
      for (int j = 0; j < 8; j++) hash_d[j] = hash_q[j] + v_q[j];
    end
    if (cmd_i.restart) begin
      for (int j = 0; j < 8; j++) hash_d[j] = sha2_pkg::iv_fn(mode_i, 3'(j));
      fill_d = '0;
      len_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 8; j++) hash_q[j] <= sha2_pkg::iv_fn(1'b0, 3'(j));
      fill_q <= '0;
      len_q  <= '0;
    end else begin
      hash_q <= hash_d;
      fill_q <= fill_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    v_q   <= v_d;
    if (cmd_i.load) begin
      word_q <= word_i;
      cnt_q  <= cnt_sat;
      end_q  <= end_i;
    end
  end

  assign sts_o.fill    = fill_q;
  assign sts_o.cnt     = cnt_q;
  assign sts_o.msg_end = end_q;
  assign digest_o      = hash_q[cmd_i.oidx];

endmodule

FILE: sv/sha2_ctrl.sv
// controller: byte sequencing, padding, round count and digest output
`timescale 1ns / 1ps

module sha2_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mode_i,
  input  logic              cfg_wr_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_last_o,
  input  sha2_pkg::status_t sts_i,
  output sha2_pkg::cmd_t    cmd_o
);

  sha2_pkg::state_e state_q, state_d, ret_q, ret_d;
  logic [2:0] bi_q, bi_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] oi_q, oi_d;
  logic       full;

  assign full = (sts_i.fill == sha2_pkg::FillLast);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    bi_d    = bi_q;
    rnd_d   = rnd_q;
    oi_d    = oi_q;
    cmd_o   = '0;
    cmd_o.bsel    = sha2_pkg::BS_DATA;
    cmd_o.bidx    = bi_q[1:0];
    cmd_o.rnd_idx = rnd_q;
    cmd_o.oidx    = oi_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_last_o  = 1'b0;
    unique case (state_q)
      sha2_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.restart = cfg_wr_i;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          bi_d = '0;
          state_d = sha2_pkg::ST_DATA;
        end
      end
      sha2_pkg::ST_DATA: begin
        if (bi_q < sts_i.cnt) begin
          cmd_o.put = 1'b1;
          bi_d = bi_q + 3'd1;
          if (full) begin
            cmd_o.init_rnd = 1'b1;
            ret_d = sha2_pkg::ST_DATA;
            state_d = sha2_pkg::ST_ROUND;
          end
        end else if (sts_i.msg_end) begin
          state_d = sha2_pkg::ST_PAD;
        end else begin
          state_d = sha2_pkg::ST_IDLE;
        end
      end
      sha2_pkg::ST_PAD: begin
        cmd_o.put  = 1'b1;
        cmd_o.bsel = sha2_pkg::BS_PAD;
        state_d = sha2_pkg::ST_ZERO;
        if (full) begin
          cmd_o.init_rnd = 1'b1;
          ret_d = sha2_pkg::ST_ZERO;
          state_d = sha2_pkg::ST_ROUND;
        end
      end
      sha2_pkg::ST_ZERO: begin
        if (sts_i.fill == sha2_pkg::FillLen) begin
          state_d = sha2_pkg::ST_LEN;
        end else begin
          cmd_o.put  = 1'b1;
          cmd_o.bsel = sha2_pkg::BS_ZERO;
          if (full) begin
            cmd_o.init_rnd = 1'b1;
            ret_d = sha2_pkg::ST_ZERO;
            state_d = sha2_pkg::ST_ROUND;
          end
        end
      end
      sha2_pkg::ST_LEN: begin
        cmd_o.put  = 1'b1;
        cmd_o.bsel = sha2_pkg::BS_LEN;
        if (full) begin
          cmd_o.init_rnd = 1'b1;
          ret_d = sha2_pkg::ST_OUT;
          oi_d  = '0;
          state_d = sha2_pkg::ST_ROUND;
        end
      end
      sha2_pkg::ST_ROUND: begin
        cmd_o.rnd_step = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == sha2_pkg::LastRound) begin
          state_d = sha2_pkg::ST_FIN;
        end
      end
      sha2_pkg::ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = ret_q;
      end
      sha2_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        out_last_o  = (oi_q == (mode_i ? 3'd6 : 3'd7));
        if (out_ready_i) begin
          oi_d = oi_q + 3'd1;
          if (out_last_o) begin
            cmd_o.restart = 1'b1;
            state_d = sha2_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = sha2_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha2_pkg::ST_IDLE;
      ret_q   <= sha2_pkg::ST_IDLE;
      bi_q    <= '0;
      rnd_q   <= '0;
      oi_q    <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      bi_q    <= bi_d;
      rnd_q   <= rnd_d;
      oi_q    <= oi_d;
    end
  end

endmodule

FILE: sv/sha256_sha224_hasher.sv
// top level of the streaming sha-256/224 hasher
`timescale 1ns / 1ps

// Streaming SHA-256/SHA-224 hasher. Message words enter big-endian with a
// byte count; the block packs bytes one per clock while no compression runs,
// so a full word costs its accept, four byte writes and the return to idle,
// and each 64-byte block adds 64 rounds and the hash update, set by the single
// shared round unit. The final word adds the padding bytes and the length,
// written the same way, and the last compression before 8 digest words (7 in
// SHA-224 mode) appear, one per accepted output transaction.
// mode_224 at address 0 selects SHA-224 and restarts the hasher; write it
// only while idle.

module sha256_sha224_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // data_word[31:0], byte_count[34:32], zero pad
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero pad
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sha2_pkg::cmd_t    cmd;
  sha2_pkg::status_t sts;
  logic        mode_q;
  logic        cfg_wr;
  logic [31:0] digest;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
  assign prdata = (paddr == 3'd0) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_wr) begin
      mode_q <= pwdata[0];
    end
  end

  sha2_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .cfg_wr_i    (cfg_wr),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sha2_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mode_i   (cfg_wr ? pwdata[0] : mode_q),
    .word_i   (s_axis_tdata[31:0]),
    .cnt_i    (s_axis_tdata[34:32]),
    .end_i    (s_axis_tlast),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .digest_o (digest)
  );

  assign m_axis_tdata = {5'd0, cmd.oidx, digest};

endmodule

FILE: sv/sha2_chk.sv
// port-level checker for the hasher, bound to the top level
`timescale 1ns / 1ps

module sha2_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while digest pending");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tdata[34:32] == 3'd7 || m_axis_tdata[34:32] == 3'd6))
    else $error("last digest word at wrong index");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    else $error("digest index did not advance");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready after digest");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled digest changed");

endmodule

bind sha256_sha224_hasher sha2_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: dv/testbench.sv
// self-checking testbench for the streaming sha-256/224 hasher
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] RegMode224 = 3'd0;
  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned SettleCycles = 250;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        last;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sha256_sha224_hasher dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  msg_word_t    word_q[$];
  digest_word_t digest_q[$];
  int unsigned  fail_cnt = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  phase = 0;
  int unsigned  item_cnt = 0;
  int unsigned  sent_cnt = 0;
  int unsigned  taken_cnt = 0;
  bit           hold_send = 1'b0;
  int unsigned  rx_hold_reqs = 0;
  int unsigned  rx_hold_seen = 0;
  int unsigned  rx_hold_left = 0;

  // predictor state
  logic        mode_q;
  logic [31:0] hash_q[8];
  logic [31:0] block_q[16];
  int unsigned fill_q;
  logic [60:0] len_q;

  function automatic logic [31:0] ror(logic [31:0] x, int unsigned n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic logic [31:0] iv_word(logic m, int unsigned i);
    logic [31:0] iv256[8];
    logic [31:0] iv224[8];
    iv256 = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    iv224 = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
              32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
    return m ? iv224[i] : iv256[i];
  endfunction

  task automatic hash_restart();
    for (int i = 0; i < 8; i++) hash_q[i] = iv_word(mode_q, i);
    fill_q = 0;
    len_q = '0;
  endtask

  task automatic compress_block();
    logic [31:0] kt[64];
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] s0, s1, t1, t2, ch, mj;
    kt = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
           32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
           32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
           32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
           32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
           32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
           32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
           32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
           32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
           32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
           32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
           32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
           32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    for (int i = 0; i < 16; i++) w[i] = block_q[i];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_q[i];
    for (int i = 0; i < 64; i++) begin
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) + ch + kt[i] + w[i];
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] = hash_q[i] + v[i];
  endtask

  task automatic push_byte(logic [7:0] b);
    block_q[fill_q / 4][24 - 8 * (fill_q % 4) +: 8] = b;
    fill_q++;
    if (fill_q == 64) begin
      compress_block();
      fill_q = 0;
    end
  endtask

  task automatic hash_word(msg_word_t mw);
    int unsigned n;
    int unsigned cnt;
    logic [63:0] bits;
    digest_word_t dw;
    n = (mw.cnt > 3'd4) ? 4 : int'(mw.cnt);
    for (int i = 0; i < n; i++) push_byte(mw.data[31 - 8 * i -: 8]);
    len_q = len_q + 61'(n);
    if (mw.last) begin
      bits = {len_q, 3'b000};
      push_byte(8'h80);
      while (fill_q != 56) push_byte(8'h00);
      for (int i = 0; i < 8; i++) push_byte(bits[63 - 8 * i -: 8]);
      cnt = mode_q ? 7 : 8;
      for (int i = 0; i < cnt; i++) begin
        dw.digest = hash_q[i];
        dw.index = 3'(i);
        dw.last = (i + 1 == cnt);
        digest_q.push_back(dw);
      end
      hash_restart();
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    fail_cnt++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // sender
  always @(negedge clk_i) begin
    if (taken_cnt == sent_cnt) begin
      if (word_q.size() > 0 && !hold_send &&
          $urandom_range(99, 0) >= (phase == 0 ? 21 : phase == 1 ? 55 : 0)) begin
        msg_word_t mw;
        mw = word_q.pop_front();
        sent_cnt++;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, mw.cnt, mw.data};
        s_axis_tlast <= mw.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rx_hold_seen != rx_hold_reqs) begin
      rx_hold_seen = rx_hold_reqs;
      rx_hold_left = 600;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99, 0) >= (phase == 0 ? 55 : phase == 1 ? 21 : 0);
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mode_q = 1'b0;
      for (int i = 0; i < 16; i++) block_q[i] = '0;
      hash_restart();
    end else begin
      idle_cycles++;
      if (psel && penable && pwrite && pready && paddr == RegMode224) begin
        mode_q = pwdata[0];
        hash_restart();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        msg_word_t mw;
        mw.data = s_axis_tdata[31:0];
        mw.cnt = s_axis_tdata[34:32];
        mw.last = s_axis_tlast;
        hash_word(mw);
        taken_cnt++;
        idle_cycles = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        if (digest_q.size() == 0) begin
          report("unexpected digest transaction", m_axis_tdata[31:0], '0);
        end else begin
          digest_word_t dw;
          dw = digest_q.pop_front();
          if (m_axis_tdata[31:0] !== dw.digest)
            report("digest_word", m_axis_tdata[31:0], dw.digest);
          if (m_axis_tdata[34:32] !== dw.index)
            report("word_index", 32'(m_axis_tdata[34:32]), 32'(dw.index));
          if (m_axis_tlast !== dw.last)
            report("last_word", 32'(m_axis_tlast), 32'(dw.last));
        end
      end
      if (psel && penable) idle_cycles = 0;
      if (idle_cycles >= WatchLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_mode(logic m);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= RegMode224;
    pwdata <= {31'b0, m};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (word_q.size() > 0 || s_axis_tvalid || digest_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic add_word(logic [31:0] data, logic [2:0] cnt, logic last);
    msg_word_t mw;
    mw.data = data;
    mw.cnt = cnt;
    mw.last = last;
    word_q.push_back(mw);
    item_cnt++;
  endtask

  task automatic add_message(int unsigned nwords, logic [2:0] end_cnt);
    for (int i = 0; i < nwords; i++) add_word($urandom, 3'd4, 1'b0);
    add_word($urandom, end_cnt, 1'b1);
  endtask

  task automatic add_random(int unsigned target);
    int unsigned nw;
    while (item_cnt < target) begin
      nw = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 14) : $urandom_range(12, 0);
      for (int i = 0; i < nw; i++)
        add_word($urandom,
                 ($urandom_range(9, 0) == 0) ? 3'($urandom_range(7, 0)) : 3'd4, 1'b0);
      add_word($urandom, 3'($urandom_range(7, 0)), 1'b1);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_mode(1'b0);

    // directed: empty message, "abc", extremes, odd byte counts
    add_word(32'h0, 3'd0, 1'b1);
    add_word(32'h61626300, 3'd3, 1'b1);
    add_word(32'hffffffff, 3'd4, 1'b0);
    add_word(32'h00000000, 3'd4, 1'b0);
    add_word(32'hffffffff, 3'd7, 1'b0);
    add_word(32'haa000000, 3'd1, 1'b0);
    add_word(32'h12345678, 3'd0, 1'b0);
    add_word(32'h55555555, 3'd5, 1'b1);
    add_word(32'hdeadbeef, 3'd6, 1'b1);
    add_message(13, 3'd3);
    add_message(14, 3'd0);
    wait_idle();

    // partial message abandoned by a mode write
    add_word(32'hcafef00d, 3'd4, 1'b0);
    add_word(32'h01020304, 3'd2, 1'b0);
    wait_idle();
    write_mode(1'b1);
    add_word(32'h61626300, 3'd3, 1'b1);
    add_random(145);
    wait_idle();

    phase = 1;
    write_mode(1'b0);
    add_random(290);
    wait_idle();

    phase = 2;
    write_mode(1'b1);
    rx_hold_reqs++;
    add_random(360);
    while (word_q.size() > 40) @(posedge clk_i);
    hold_send = 1'b1;
    while (s_axis_tvalid || digest_q.size() > 0) @(posedge clk_i);
    hold_send = 1'b0;
    add_random(430);
    wait_idle();

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sha256_sha224_hasher.f
sv/sha2_pkg.sv
sv/sha2_dp.sv
sv/sha2_ctrl.sv
sv/sha256_sha224_hasher.sv
sv/sha2_chk.sv
dv/testbench.sv
